// ===== design/ciso_pkg.sv =====
package ciso_pkg;

  // Container layout and limits.
  localparam int unsigned HDR_BYTES       = 24;
  localparam int unsigned MAX_BLOCKS      = 4000000;
  localparam int unsigned MAX_BLOCK_BYTES = 4 * 1024 * 1024;
  localparam int unsigned MAX_SHIFT       = 31;
  localparam int unsigned SLACK_BYTES     = 64;

  // "CISO", first byte in the lowest bits.
  localparam logic [31:0] MAGIC = 32'h4F53_4943;

  // Header byte positions that matter.
  localparam logic [4:0] POS_TOTAL_LO = 5'd8;
  localparam logic [4:0] POS_TOTAL_HI = 5'd15;
  localparam logic [4:0] POS_BSIZE_LO = 5'd16;
  localparam logic [4:0] POS_BSIZE_HI = 5'd19;
  localparam logic [4:0] POS_ALIGN    = 5'd21;
  localparam logic [4:0] POS_END      = 5'd23;

  // Result field widths.
  localparam int unsigned NUM_W = 22;
  localparam int unsigned OFS_W = 62;

  // Packing of the result tdata, lowest bit first.
  localparam int unsigned TD_NUM_LSB    = 0;
  localparam int unsigned TD_START_LSB  = TD_NUM_LSB + NUM_W;
  localparam int unsigned TD_LEN_LSB    = TD_START_LSB + OFS_W;
  localparam int unsigned TD_STORED_BIT = TD_LEN_LSB + OFS_W;
  localparam int unsigned TD_ERR_LSB    = TD_STORED_BIT + 1;
  localparam int unsigned TD_W          = 152;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BLOCK  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_SHORT      = 4'd1,
    ERR_MAGIC      = 4'd2,
    ERR_FIELD      = 4'd3,
    ERR_INDEX      = 4'd4,
    ERR_ORDER      = 4'd5,
    ERR_BEYOND     = 4'd6,
    ERR_STORED     = 4'd7,
    ERR_COMPRESSED = 4'd8
  } err_code_t;

  typedef struct packed {
    kind_t             kind;
    logic [NUM_W-1:0]  num;
    logic [OFS_W-1:0]  start;
    logic [OFS_W-1:0]  len;
    logic              stored;
    err_code_t         err;
    logic              last;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic      clear;
    logic      hdr_byte;
    logic      div_start;
    logic      div_step;
    logic      hdr_commit;
    logic      idx_byte;
    logic      word_to_prev;
    logic      word_to_next;
    logic      ix_shift;
    logic      ix_diff;
    logic      desc_commit;
    logic      emit;
    kind_t     emit_kind;
    err_code_t emit_err;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic      too_short;
    logic      hdr_emit_pos;
    logic      hdr_end;
    err_code_t hdr_err;
    logic      word_end;
    logic      div_last;
    err_code_t hdr_chk_err;
    err_code_t ix_err;
    logic      ix_last;
    logic      out_busy;
  } status_t;

endpackage

// ===== design/ciso_dp.sv =====
module ciso_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_first,
  input  logic [7:0]                    in_byte,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ciso_pkg::OFS_W-1:0]    cfg_data,
  input  ciso_pkg::cmd_t                cmd,
  output ciso_pkg::status_t             st,
  input  logic                          out_ready,
  output logic                          out_valid,
  output ciso_pkg::out_item_t           out_item
);

  logic [61:0] fs_r;
  logic [4:0]  hdr_cnt_r;
  logic [63:0] total_r;
  logic [31:0] acc_r;
  logic [22:0] bb_r;
  logic [4:0]  align_r;
  logic [1:0]  word_cnt_r;
  logic [31:0] prev_r;
  logic [31:0] next_r;
  logic [22:0] tot_r;
  logic [21:0] cnt_r;
  logic [59:0] avail_r;
  logic [63:0] dvd_r;
  logic [22:0] rem_r;
  logic [5:0]  div_cnt_r;
  logic [61:0] start_r;
  logic [61:0] end_r;
  logic [61:0] extent_r;
  logic        lt_r;
  logic        gt_r;
  logic        stored_r;
  logic        out_valid_r;
  ciso_pkg::out_item_t out_r;
  ciso_pkg::out_item_t out_nxt;

  logic [4:0]  eff_pos;
  logic [31:0] word_in;
  logic [61:0] fs_m24;
  logic [23:0] div_sh;
  logic [23:0] div_diff;
  logic        div_ge;
  logic [23:0] need;
  logic [21:0] cnt_inc;
  logic [23:0] comp_lim;

  assign cfg_ready = 1'b1;
  assign eff_pos   = in_first ? 5'd0 : hdr_cnt_r;
  assign word_in   = {in_byte, acc_r[31:8]};
  assign fs_m24    = fs_r - 62'(ciso_pkg::HDR_BYTES);
  assign div_sh    = {rem_r, dvd_r[63]};
  assign div_diff  = div_sh - {1'b0, bb_r};
  assign div_ge    = div_sh >= {1'b0, bb_r};
  assign need      = 24'(dvd_r[22:0]) + 24'd1;
  assign cnt_inc   = cnt_r + 22'd1;
  assign comp_lim  = {bb_r, 1'b0} + 24'(ciso_pkg::SLACK_BYTES);

  // Status towards the controller.
  always_comb begin
    st              = '0;
    st.too_short    = fs_r <= 62'(ciso_pkg::HDR_BYTES);
    st.hdr_emit_pos = (eff_pos < 5'd4) || (eff_pos == ciso_pkg::POS_BSIZE_HI) ||
                      (eff_pos == ciso_pkg::POS_ALIGN);
    st.hdr_end      = eff_pos == ciso_pkg::POS_END;
    st.word_end     = word_cnt_r == 2'd3;
    st.div_last     = div_cnt_r == 6'd63;
    st.out_busy     = out_valid_r;
    st.ix_last      = {1'b0, cnt_inc} >= tot_r;

    priority if ((eff_pos < 5'd4) && (in_byte != ciso_pkg::MAGIC[{eff_pos[1:0], 3'b000} +: 8]))
      st.hdr_err = ciso_pkg::ERR_MAGIC;
    else if ((eff_pos == ciso_pkg::POS_BSIZE_HI) &&
             ((total_r == '0) || (word_in == '0) ||
              (word_in > 32'(ciso_pkg::MAX_BLOCK_BYTES))))
      st.hdr_err = ciso_pkg::ERR_FIELD;
    else if ((eff_pos == ciso_pkg::POS_ALIGN) && (in_byte > 8'(ciso_pkg::MAX_SHIFT)))
      st.hdr_err = ciso_pkg::ERR_FIELD;
    else
      st.hdr_err = ciso_pkg::ERR_NONE;

    priority if (rem_r != '0)
      st.hdr_chk_err = ciso_pkg::ERR_FIELD;
    else if ((dvd_r == '0) || (dvd_r > 64'(ciso_pkg::MAX_BLOCKS)))
      st.hdr_chk_err = ciso_pkg::ERR_FIELD;
    else if (60'(need) > avail_r)
      st.hdr_chk_err = ciso_pkg::ERR_INDEX;
    else
      st.hdr_chk_err = ciso_pkg::ERR_NONE;

    priority if (lt_r)
      st.ix_err = ciso_pkg::ERR_ORDER;
    else if (gt_r)
      st.ix_err = ciso_pkg::ERR_BEYOND;
    else if (stored_r && (extent_r[61:23] == '0) && (extent_r[22:0] < bb_r))
      st.ix_err = ciso_pkg::ERR_STORED;
    else if (!stored_r && ((extent_r == '0) || (extent_r[61:24] != '0) ||
                           (extent_r[23:0] > comp_lim)))
      st.ix_err = ciso_pkg::ERR_COMPRESSED;
    else
      st.ix_err = ciso_pkg::ERR_NONE;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= '0;
    end else if (cfg_valid) begin
      fs_r <= cfg_data;
    end
  end

  // Parse counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r  <= '0;
      word_cnt_r <= '0;
      cnt_r      <= '0;
    end else begin
      if (cmd.hdr_byte) begin
        hdr_cnt_r <= eff_pos + 5'd1;
      end else if (cmd.clear) begin
        hdr_cnt_r <= '0;
      end
      if (cmd.clear || cmd.hdr_commit) begin
        word_cnt_r <= '0;
      end else if (cmd.idx_byte) begin
        word_cnt_r <= word_cnt_r + 2'd1;
      end
      if (cmd.clear || cmd.hdr_commit) begin
        cnt_r <= '0;
      end else if (cmd.desc_commit) begin
        cnt_r <= cnt_inc;
      end
    end
  end

  // Header fields, index words and the divider.
  always_ff @(posedge clk) begin
    if (cmd.hdr_byte) begin
      if ((eff_pos >= ciso_pkg::POS_TOTAL_LO) && (eff_pos <= ciso_pkg::POS_TOTAL_HI)) begin
        total_r <= {in_byte, total_r[63:8]};
      end
      if ((eff_pos >= ciso_pkg::POS_BSIZE_LO) && (eff_pos <= ciso_pkg::POS_BSIZE_HI)) begin
        acc_r <= word_in;
      end
      if (eff_pos == ciso_pkg::POS_BSIZE_HI) begin
        bb_r <= word_in[22:0];
      end
      if (eff_pos == ciso_pkg::POS_ALIGN) begin
        align_r <= in_byte[4:0];
      end
    end else if (cmd.idx_byte) begin
      acc_r <= word_in;
    end
    if (cmd.word_to_prev) begin
      prev_r <= word_in;
    end else if (cmd.desc_commit) begin
      prev_r <= next_r;
    end
    if (cmd.word_to_next) begin
      next_r <= word_in;
    end
    if (cmd.div_start) begin
      dvd_r     <= total_r;
      rem_r     <= '0;
      div_cnt_r <= '0;
      avail_r   <= (fs_r > 62'(ciso_pkg::HDR_BYTES)) ? fs_m24[61:2] : '0;
    end else if (cmd.div_step) begin
      dvd_r     <= {dvd_r[62:0], div_ge};
      rem_r     <= div_ge ? div_diff[22:0] : div_sh[22:0];
      div_cnt_r <= div_cnt_r + 6'd1;
    end
    if (cmd.hdr_commit) begin
      tot_r <= dvd_r[22:0];
    end
    if (cmd.ix_shift) begin
      start_r  <= {31'd0, prev_r[30:0]} << align_r;
      end_r    <= {31'd0, next_r[30:0]} << align_r;
      stored_r <= prev_r[31];
    end
    if (cmd.ix_diff) begin
      extent_r <= end_r - start_r;
      lt_r     <= end_r < start_r;
      gt_r     <= end_r > fs_r;
    end
  end

  // Output register.
  always_comb begin
    out_nxt = '0;
    unique case (cmd.emit_kind)
      ciso_pkg::KIND_HEADER: begin
        out_nxt.kind = ciso_pkg::KIND_HEADER;
        out_nxt.num  = dvd_r[21:0];
        out_nxt.len  = 62'(bb_r);
        out_nxt.err  = ciso_pkg::ERR_NONE;
      end
      ciso_pkg::KIND_BLOCK: begin
        out_nxt.kind   = ciso_pkg::KIND_BLOCK;
        out_nxt.num    = cnt_r;
        out_nxt.start  = start_r;
        out_nxt.len    = stored_r ? 62'(bb_r) : extent_r;
        out_nxt.stored = stored_r;
        out_nxt.err    = ciso_pkg::ERR_NONE;
        out_nxt.last   = st.ix_last;
      end
      ciso_pkg::KIND_ERROR: begin
        out_nxt.kind = ciso_pkg::KIND_ERROR;
        out_nxt.num  = cmd.clear ? '0 : cnt_r;
        out_nxt.err  = cmd.emit_err;
      end
      default: begin
        out_nxt.kind = ciso_pkg::KIND_ERROR;
        out_nxt.err  = cmd.emit_err;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== design/ciso_ctrl.sv =====
module ciso_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_first,
  output logic                 in_tready,
  input  ciso_pkg::status_t    st,
  output ciso_pkg::cmd_t       cmd
);

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_HEADER    = 10'b00_0000_0010,
    ST_DIV       = 10'b00_0000_0100,
    ST_HDR_CHK   = 10'b00_0000_1000,
    ST_IDX_FIRST = 10'b00_0001_0000,
    ST_IDX_PAIR  = 10'b00_0010_0000,
    ST_IX_SHIFT  = 10'b00_0100_0000,
    ST_IX_DIFF   = 10'b00_1000_0000,
    ST_IX_CHK    = 10'b01_0000_0000,
    ST_STOPPED   = 10'b10_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept_st;
  logic   in_hdr;
  logic   may_emit;
  logic   acc;

  assign accept_st = (state_r == ST_IDLE) || (state_r == ST_HEADER) ||
                     (state_r == ST_IDX_FIRST) || (state_r == ST_IDX_PAIR) ||
                     (state_r == ST_STOPPED);
  assign in_hdr    = in_first || (state_r == ST_HEADER);
  assign may_emit  = in_first || ((state_r == ST_HEADER) && st.hdr_emit_pos);
  assign in_tready = accept_st && (!may_emit || !st.out_busy);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE, ST_HEADER, ST_IDX_FIRST, ST_IDX_PAIR, ST_STOPPED: begin
        if (acc) begin
          cmd.clear = in_first;
          priority if (in_first && st.too_short) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = ciso_pkg::KIND_ERROR;
            cmd.emit_err  = ciso_pkg::ERR_SHORT;
            state_nxt     = ST_STOPPED;
          end else if (in_hdr) begin
            cmd.hdr_byte = 1'b1;
            priority if (st.hdr_err != ciso_pkg::ERR_NONE) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = ciso_pkg::KIND_ERROR;
              cmd.emit_err  = st.hdr_err;
              state_nxt     = ST_STOPPED;
            end else if (st.hdr_end) begin
              cmd.div_start = 1'b1;
              state_nxt     = ST_DIV;
            end else begin
              state_nxt = ST_HEADER;
            end
          end else if ((state_r == ST_IDX_FIRST) || (state_r == ST_IDX_PAIR)) begin
            cmd.idx_byte = 1'b1;
            if (st.word_end) begin
              if (state_r == ST_IDX_FIRST) begin
                cmd.word_to_prev = 1'b1;
                state_nxt        = ST_IDX_PAIR;
              end else begin
                cmd.word_to_next = 1'b1;
                state_nxt        = ST_IX_SHIFT;
              end
            end
          end else begin
            state_nxt = state_r;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = ST_HDR_CHK;
        end
      end
      ST_HDR_CHK: begin
        if (!st.out_busy) begin
          cmd.emit = 1'b1;
          if (st.hdr_chk_err != ciso_pkg::ERR_NONE) begin
            cmd.emit_kind = ciso_pkg::KIND_ERROR;
            cmd.emit_err  = st.hdr_chk_err;
            state_nxt     = ST_STOPPED;
          end else begin
            cmd.emit_kind  = ciso_pkg::KIND_HEADER;
            cmd.hdr_commit = 1'b1;
            state_nxt      = ST_IDX_FIRST;
          end
        end
      end
      ST_IX_SHIFT: begin
        cmd.ix_shift = 1'b1;
        state_nxt    = ST_IX_DIFF;
      end
      ST_IX_DIFF: begin
        cmd.ix_diff = 1'b1;
        state_nxt   = ST_IX_CHK;
      end
      ST_IX_CHK: begin
        if (!st.out_busy) begin
          cmd.emit = 1'b1;
          if (st.ix_err != ciso_pkg::ERR_NONE) begin
            cmd.emit_kind = ciso_pkg::KIND_ERROR;
            cmd.emit_err  = st.ix_err;
            state_nxt     = ST_STOPPED;
          end else begin
            cmd.emit_kind   = ciso_pkg::KIND_BLOCK;
            cmd.desc_commit = 1'b1;
            state_nxt       = st.ix_last ? ST_STOPPED : ST_IDX_PAIR;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/ciso_header_index_parser.sv =====
// Channel  Direction  tvalid/tready          Payload
// in_      slave      in_tvalid/in_tready    tdata: data_byte; tuser: first
// out_     master     out_tvalid/out_tready  tdata: descriptor fields; tuser: kind; tlast: last
// cfg_     slave      cfg_valid/cfg_ready    data: file_size
//
// Header bytes are taken one per cycle, save where a byte that can raise a result waits for
// the output register. After the last header byte the block count is found by a restoring
// divider that retires one quotient bit per cycle; the input stalls while it runs and while
// the header checks are made. Each index word takes four byte transfers; each word after
// the first then takes three steps (shift, difference, check) to form a block descriptor.
// Synchronous active-low reset clears the state, counters, file_size and out_tvalid.
// in_tready drops while the divider, header check or descriptor steps run, and for a byte
// that can raise a result while the output register still holds an untaken transfer.

module ciso_header_index_parser (
  input  logic         clk,
  input  logic         rst_n,

  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] data_byte
  input  logic         in_tuser,    // [0] first

  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata,   // [21:0] block_number, [83:22] start_offset,
                                    // [145:84] length, [146] stored,
                                    // [150:147] error_code, [151] zero
  output logic [1:0]   out_tuser,   // [1:0] kind
  output logic         out_tlast,   // last

  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [61:0]  cfg_data     // file_size
);

  ciso_pkg::cmd_t      cmd;
  ciso_pkg::status_t   st;
  ciso_pkg::out_item_t item;

  // The controller sequences the parse and owns the input handshake.
  ciso_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_first  (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath holds the header fields, the divider, the index words and the
  // output register that decouples the result channel from the input.
  ciso_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_first  (in_tuser),
    .in_byte   (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_item  (item)
  );

  // Fields are packed lowest first, with one zero bit to round up to whole bytes.
  assign out_tdata = {1'b0, item.err, item.stored, item.len, item.start, item.num};
  assign out_tuser = item.kind;
  assign out_tlast = item.last;

endmodule

// ===== design/ciso_chk.sv =====
module ciso_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [151:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);

  logic [3:0]  err_f;
  logic [61:0] start_f;
  logic [61:0] len_f;

  assign err_f   = out_tdata[ciso_pkg::TD_ERR_LSB +: 4];
  assign start_f = out_tdata[ciso_pkg::TD_START_LSB +: ciso_pkg::OFS_W];
  assign len_f   = out_tdata[ciso_pkg::TD_LEN_LSB +: ciso_pkg::OFS_W];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ciso_pkg::KIND_ERROR) |->
      (err_f != ciso_pkg::ERR_NONE) && (start_f == '0) && (len_f == '0) && !out_tlast)
    else $error("malformed error result");

  a_code_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ciso_pkg::KIND_ERROR) |-> (err_f == ciso_pkg::ERR_NONE))
    else $error("error code on a non-error result");

  a_last_on_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (out_tuser == ciso_pkg::KIND_BLOCK))
    else $error("last flag outside a block descriptor");

endmodule

bind ciso_header_index_parser ciso_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
